>>> rtl/bbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared types and constants for the Bollinger band tracker.
// ----------------------------------------------------------------------------
package bbt_pkg;

   localparam int WL_BITS    = 7;
   localparam int COEFF_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int CSR_BITS   = 12;

   localparam logic [1:0] SIG_NONE = 2'd0;
   localparam logic [1:0] SIG_SELL = 2'd1;
   localparam logic [1:0] SIG_BUY  = 2'd2;

   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_BAND_COEFF    = 1'b1;

   // status of a bit-serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

>>> rtl/bollinger_band_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bollinger_band_tracker
// Moving average, deviation, bands and trade signal over a price window.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one closing price per beat; req_stall is high
//    while an item is in work, so one item is processed at a time.
//  - rsp_ channel carries one result beat per price once window_length
//    prices have been seen; before that a price only fills the window.
//  - csr_ port writes window_length (index 0, empties the window) and
//    band_coeff (index 1); write only while idle.
// While the window fills a price is accepted in S_IDLE and written to the
// ring in S_UPD. With a full window the update is followed by the mean
// divide, the window walk, the multiply by L, the variance divide, the
// square root, and the offset and output steps. The divider works on
// N = 2*PRICE_BITS + 2*clog2(MAX_WINDOW+1) = 62 numerator bits, the
// multiply on W = clog2(MAX_WINDOW+1) = 7 bits of L and the root on P =
// PRICE_BITS bits. The next price is taken once the block is back in S_IDLE.
// Results sit in an output register: a new price is taken while a result
// waits; the block holds before its next result while rsp_stall is high.
// Reset empties the window, sets window_length 20 and band_coeff 2.0.
// ----------------------------------------------------------------------------
module bollinger_band_tracker #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [PRICE_BITS-1:0]         req_close_price,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [PRICE_BITS-1:0]         rsp_middle_band,
   output logic [PRICE_BITS-1:0]         rsp_std_dev,
   output logic [PRICE_BITS-1:0]         rsp_upper_band,
   output logic [PRICE_BITS-1:0]         rsp_lower_band,
   output logic [1:0]                    rsp_trade_signal,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [bbt_pkg::CSR_BITS-1:0]  csr_data
);
   localparam int PB   = PRICE_BITS;
   localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LW   = $clog2(MAX_WINDOW + 1);
   localparam int SW   = PB + LW;
   localparam int SQW  = 2 * PB + LW;
   localparam int NW   = SQW + LW;
   localparam int DENW = 2 * LW;
   localparam int VW   = 2 * PB;
   localparam int MCW  = $clog2(LW + 1);
   localparam int MW   = PB + bbt_pkg::COEFF_BITS;
   localparam int OW   = PB + bbt_pkg::COEFF_BITS - bbt_pkg::FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_UPD, S_MEAN, S_ACC, S_MUL, S_VAR, S_ROOT, S_OFF, S_FIN
   } state_type;

   state_type state_ff;

   logic [bbt_pkg::WL_BITS-1:0]    wl_ff;
   logic [bbt_pkg::COEFF_BITS-1:0] coeff_ff;
   logic [AW-1:0]                  slot_ff;
   logic [LW-1:0]                  filled_ff;
   logic [SW-1:0]                  sum_ff;
   logic [PB-1:0]                  price_ff;
   logic [PB-1:0]                  mean_ff;
   logic [DENW-1:0]                rem_ff;
   logic [LW-1:0]                  k_ff;
   logic                           v0_ff, v1_ff, v2_ff;
   logic signed [PB:0]             d_ff;
   logic [VW-1:0]                  p_ff;
   logic [SQW-1:0]                 sq_ff;
   logic [NW-1:0]                  mcand_ff;
   logic [LW-1:0]                  mplier_ff;
   logic [NW-1:0]                  macc_ff;
   logic [MCW-1:0]                 mcnt_ff;
   logic [PB-1:0]                  dev_ff;
   logic [OW-1:0]                  off_ff;

   logic                           rsp_valid_ff;
   logic [PB-1:0]                  mid_out_ff, dev_out_ff, up_out_ff, lo_out_ff;
   logic [1:0]                     sig_out_ff;

   logic [PB-1:0]                  price_window [MAX_WINDOW];
   logic [PB-1:0]                  rdata_ff;
   logic [AW-1:0]                  raddr;

   logic [LW-1:0]                  len;
   logic                           full_before;
   logic [SW-1:0]                  sum_in;
   logic [LW-1:0]                  filled_in;
   logic [AW-1:0]                  slot_in;
   logic                           issue;
   logic signed [2*PB+1:0]         d_sq;
   logic [PB:0]                    upper_w;
   logic [PB-1:0]                  upper_v, lower_v;
   logic [1:0]                     sig_v;
   logic                           out_free;

   logic                           div_start;
   logic [NW-1:0]                  div_num;
   logic [DENW-1:0]                div_den;
   bbt_pkg::unit_status_type       div_status;
   logic [NW-1:0]                  div_quot;
   logic [DENW-1:0]                div_rem;
   logic                           sqrt_start;
   bbt_pkg::unit_status_type       sqrt_status;
   logic [PB-1:0]                  sqrt_root;

   // effective window length, clamped to the legal range
   always_comb begin
      if (int'(wl_ff) < 2) begin
         len = LW'(2);
      end else if (int'(wl_ff) > MAX_WINDOW) begin
         len = LW'(MAX_WINDOW);
      end else begin
         len = LW'(wl_ff);
      end
   end

   assign full_before = filled_ff >= len;
   assign sum_in      = full_before ? sum_ff - SW'(rdata_ff) + SW'(price_ff)
                                    : sum_ff + SW'(price_ff);
   assign filled_in   = full_before ? filled_ff : filled_ff + 1'b1;
   assign slot_in     = (LW'(slot_ff) + 1'b1 == len) ? '0 : slot_ff + 1'b1;
   assign issue       = k_ff < len;
   assign d_sq        = d_ff * d_ff;
   assign raddr       = (state_ff == S_IDLE) ? slot_ff : k_ff[AW-1:0];

   assign div_start = ((state_ff == S_UPD) && (filled_in == len))
                   || ((state_ff == S_MUL) && (mcnt_ff == '0));
   assign div_num   = (state_ff == S_UPD) ? NW'(sum_in)
                    : macc_ff - NW'(rem_ff * rem_ff);
   assign div_den   = (state_ff == S_UPD) ? DENW'(len) : DENW'(len * len);
   assign sqrt_start = (state_ff == S_VAR) && div_status.done;

   assign upper_w = {1'b0, mean_ff} + (PB+1)'(off_ff);
   assign upper_v = (upper_w[PB] || (OW > PB && |off_ff[OW-1:PB < OW ? PB : 0] && OW > PB))
                    ? {PB{1'b1}} : upper_w[PB-1:0];
   assign lower_v = ((PB+OW)'(mean_ff) > (PB+OW)'(off_ff))
                    ? PB'((PB+OW)'(mean_ff) - (PB+OW)'(off_ff)) : '0;
   always_comb begin
      if (price_ff > upper_v) begin
         sig_v = bbt_pkg::SIG_SELL;
      end else if (price_ff < lower_v) begin
         sig_v = bbt_pkg::SIG_BUY;
      end else begin
         sig_v = bbt_pkg::SIG_NONE;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;

   bbt_div #(.NUM_BITS(NW), .DEN_BITS(DENW)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_num),
      .denom  (div_den),
      .status (div_status),
      .quot   (div_quot),
      .rem    (div_rem)
   );

   bbt_sqrt #(.VAL_BITS(VW)) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .value  (div_quot[VW-1:0]),
      .status (sqrt_status),
      .root   (sqrt_root)
   );

   // price ring
   always_ff @(posedge clock) begin
      if (state_ff == S_UPD) begin
         price_window[slot_ff] <= price_ff;
      end
      rdata_ff <= price_window[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wl_ff        <= bbt_pkg::WL_BITS'(20);
         coeff_ff     <= bbt_pkg::COEFF_BITS'(512);
         slot_ff      <= '0;
         filled_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  price_ff <= req_close_price;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               sum_ff    <= sum_in;
               filled_ff <= filled_in;
               slot_ff   <= slot_in;
               state_ff  <= (filled_in == len) ? S_MEAN : S_IDLE;
            end
            S_MEAN: begin
               if (div_status.done) begin
                  mean_ff  <= div_quot[PB-1:0];
                  rem_ff   <= div_rem;
                  sq_ff    <= '0;
                  k_ff     <= '0;
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               // walk the window one entry per cycle
               v0_ff <= issue;
               v1_ff <= v0_ff;
               v2_ff <= v1_ff;
               if (issue) begin
                  k_ff <= k_ff + 1'b1;
               end
               d_ff <= $signed({1'b0, rdata_ff}) - $signed({1'b0, mean_ff});
               p_ff <= VW'(unsigned'(d_sq));
               if (v2_ff) begin
                  sq_ff <= sq_ff + SQW'(p_ff);
               end
               if (!issue && !v0_ff && !v1_ff && !v2_ff) begin
                  mcand_ff  <= NW'(sq_ff);
                  mplier_ff <= len;
                  macc_ff   <= '0;
                  mcnt_ff   <= MCW'(LW);
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               // shift-add: one multiplier bit per cycle
               if (mcnt_ff == '0) begin
                  state_ff <= S_VAR;
               end else begin
                  if (mplier_ff[0]) begin
                     macc_ff <= macc_ff + mcand_ff;
                  end
                  mcand_ff  <= {mcand_ff[NW-2:0], 1'b0};
                  mplier_ff <= mplier_ff >> 1;
                  mcnt_ff   <= mcnt_ff - 1'b1;
               end
            end
            S_VAR: begin
               if (div_status.done) begin
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (sqrt_status.done) begin
                  dev_ff   <= sqrt_root;
                  state_ff <= S_OFF;
               end
            end
            S_OFF: begin
               off_ff   <= OW'((MW'(coeff_ff) * MW'(dev_ff)) >> bbt_pkg::FRAC_BITS);
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  mid_out_ff   <= mean_ff;
                  dev_out_ff   <= dev_ff;
                  up_out_ff    <= upper_v;
                  lo_out_ff    <= lower_v;
                  sig_out_ff   <= sig_v;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_write) begin
            case (csr_index)
               bbt_pkg::CSR_WINDOW_LENGTH: begin
                  wl_ff     <= csr_data[bbt_pkg::WL_BITS-1:0];
                  slot_ff   <= '0;
                  filled_ff <= '0;
                  sum_ff    <= '0;
               end
               bbt_pkg::CSR_BAND_COEFF: begin
                  coeff_ff <= csr_data[bbt_pkg::COEFF_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_middle_band  = mid_out_ff;
   assign rsp_std_dev      = dev_out_ff;
   assign rsp_upper_band   = up_out_ff;
   assign rsp_lower_band   = lo_out_ff;
   assign rsp_trade_signal = sig_out_ff;

`ifndef NO_ASSERTIONS
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      LW'(slot_ff) < len) else $error("write slot beyond window");
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= len) else $error("fill count beyond window");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy) else $error("divider started while busy");
   a_fin_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !out_free) |=> state_ff == S_FIN)
      else $error("result dropped while output held");
`endif

endmodule

>>> rtl/bbt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbt_div #(
   parameter int NUM_BITS = 61,
   parameter int DEN_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_BITS-1:0]      numer,
   input  logic [DEN_BITS-1:0]      denom,
   output bbt_pkg::unit_status_type status,
   output logic [NUM_BITS-1:0]      quot,
   output logic [DEN_BITS-1:0]      rem
);
   localparam int CW = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] q_ff;
   logic [DEN_BITS-1:0] r_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DEN_BITS:0]   r_try;
   logic                take;

   assign r_try = {r_ff, q_ff[NUM_BITS-1]};
   assign take  = r_try >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_BITS);
            q_ff    <= numer;
            r_ff    <= '0;
            den_ff  <= denom;
         end else if (busy_ff) begin
            // shift one numerator bit into the partial remainder
            q_ff <= {q_ff[NUM_BITS-2:0], take};
            r_ff <= take ? DEN_BITS'(r_try - {1'b0, den_ff}) : r_try[DEN_BITS-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
`endif

endmodule

>>> rtl/bbt_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module bbt_sqrt #(
   parameter int VAL_BITS = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [VAL_BITS-1:0]      value,
   output bbt_pkg::unit_status_type status,
   output logic [VAL_BITS/2-1:0]    root
);
   localparam int HW = VAL_BITS / 2;
   localparam int RW = HW + 2;
   localparam int CW = $clog2(HW + 1);

   logic [VAL_BITS-1:0] v_ff;
   logic [RW-1:0]       rem_ff;
   logic [HW-1:0]       root_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [RW-1:0]       rem_try;
   logic [RW-1:0]       trial;
   logic                take;

   assign rem_try = {rem_ff[RW-3:0], v_ff[VAL_BITS-1:VAL_BITS-2]};
   assign trial   = {root_ff, 2'b01};
   assign take    = rem_try >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(HW);
            v_ff    <= value;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            v_ff    <= {v_ff[VAL_BITS-3:0], 2'b00};
            rem_ff  <= take ? rem_try - trial : rem_try;
            root_ff <= {root_ff[HW-2:0], take};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root = root_ff;

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("sqrt restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("sqrt done while busy");
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("sqrt done without work");
`endif

endmodule
